[rtl/bounded_integer_set_defines.svh]
// ----------------------------------------------------------------------------
// Bounded integer set: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_DEFINES_SVH
`define BOUNDED_INTEGER_SET_DEFINES_SVH

// condition holds at every clock edge out of reset
`define BIS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BIS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define BIS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bis_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded integer set: package
// Field widths, item kinds, result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned RESET_CAP     = 64;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DELTA_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CAP_W    = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_ADJUST = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic load;    // latch a new item
    logic search;  // register the match vector
    logic commit;  // update cells, count, capacity and result
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // output register free or emptied this cycle
  } stat_t;

endpackage

[rtl/bis_if.sv]
// ----------------------------------------------------------------------------
// Bounded integer set: channel interfaces
// Valid/ready channels for items, results and the capacity register write.
// ----------------------------------------------------------------------------
interface bis_in_if import bis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [VALUE_W-1:0]  value;
  logic signed [DELTA_W-1:0]  delta;

  modport source (output valid, kind, value, delta, input ready);
  modport sink   (input valid, kind, value, delta, output ready);
endinterface

interface bis_out_if import bis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                present;
  logic [COUNT_W-1:0]  count;
  logic [CAP_W-1:0]    capacity;

  modport source (output valid, status, present, count, capacity, input ready);
  modport sink   (input valid, status, present, count, capacity, output ready);
endinterface

interface bis_cfg_if import bis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] initial_capacity;

  modport source (output valid, initial_capacity, input ready);
  modport sink   (input valid, initial_capacity, output ready);
endinterface

[rtl/bis_dp.sv]
// ----------------------------------------------------------------------------
// Bounded integer set: datapath
// Row of compare-and-shift cells, element count, capacity and result register.
// ----------------------------------------------------------------------------
`include "bounded_integer_set_defines.svh"

module bis_dp import bis_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic signed [DELTA_W-1:0] delta_i,
  input  logic                      cfg_valid_i,
  input  logic [CAP_W-1:0]          cfg_cap_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [STATUS_W-1:0]       out_status_o,
  output logic                      out_present_o,
  output logic [COUNT_W-1:0]        out_count_o,
  output logic [CAP_W-1:0]          out_cap_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = ((CW > DELTA_W) ? CW : DELTA_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] RESET_CAP_C =
    (RESET_CAP > DEPTH) ? CW'(DEPTH) : CW'(RESET_CAP);

  kind_e                kind_q;
  logic [VALUE_W-1:0]   value_q;
  logic [DELTA_W-1:0]   delta_q;
  logic [VALUE_W-1:0]   entry_q [DEPTH];
  logic [DEPTH-1:0]     match_d, match_q;
  logic                 found_q;
  logic [DEPTH-1:0]     shift_mask;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        cap_q, cap_d;
  logic [CW-1:0]        cfg_cap;
  logic [CW-1:0]        room;
  logic [DELTA_W-1:0]   mag;
  logic [AW-1:0]        grow_sum;
  logic [AW-1:0]        take;
  status_e              status_d;
  logic                 present_d;
  logic                 add_ok;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic                 out_present_q;
  logic [COUNT_W-1:0]   out_count_q;
  logic [CAP_W-1:0]     out_cap_q;

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_e'(kind_i);
      value_q <= value_i;
      delta_q <= delta_i;
    end
  end

  // cells: each compares its own entry, takes the new value at the tail,
  // or takes its upper neighbour's entry when the gap lies at or below it
  assign shift_mask = ~(match_q - DEPTH'(1));
  assign add_ok     = !found_q && (count_q < cap_q) && (count_q < DEPTH_C);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign match_d[i] = (CW'(i) < count_q) && (entry_q[i] == value_q);

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit && kind_q == KIND_ADD && add_ok && count_q == CW'(i)) begin
        entry_q[i] <= value_q;
      end else if (cmd_i.commit && kind_q == KIND_REMOVE && shift_mask[i]) begin
        if (i < DEPTH - 1) begin
          entry_q[i] <= entry_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      match_q <= match_d;
      found_q <= |match_d;
    end
  end

  // capacity arithmetic for adjust
  assign mag      = delta_q[DELTA_W-1] ? (~delta_q + DELTA_W'(1)) : delta_q;
  assign room     = cap_q - count_q;
  assign grow_sum = AW'(cap_q) + AW'(mag);
  assign take     = (AW'(mag) < AW'(room)) ? AW'(mag) : AW'(room);
  assign cfg_cap  = (AW'(cfg_cap_i) > AW'(DEPTH)) ? DEPTH_C : CW'(cfg_cap_i);

  always_comb begin
    count_d   = count_q;
    cap_d     = cap_q;
    status_d  = STATUS_DONE;
    present_d = found_q;
    unique case (kind_q)
      KIND_ADD: begin
        if (found_q) begin
          status_d = STATUS_MISS;
        end else if (!add_ok) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (found_q) begin
          count_d = count_q - CW'(1);
        end else begin
          status_d = STATUS_MISS;
        end
        cap_d = count_d;
      end
      KIND_QUERY: begin
        status_d = found_q ? STATUS_DONE : STATUS_MISS;
      end
      KIND_ADJUST: begin
        present_d = 1'b0;
        if (!delta_q[DELTA_W-1] && delta_q != '0) begin
          cap_d = (grow_sum > AW'(DEPTH)) ? DEPTH_C : grow_sum[CW-1:0];
        end else if (delta_q[DELTA_W-1]) begin
          cap_d = cap_q - take[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= RESET_CAP_C;
    end else if (cfg_valid_i) begin
      count_q <= '0;
      cap_q   <= cfg_cap;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q  <= status_d;
      out_present_q <= present_d;
      out_count_q   <= COUNT_W'(count_d);
      out_cap_q     <= CAP_W'(cap_d);
    end
  end

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_present_o    = out_present_q;
  assign out_count_o      = out_count_q;
  assign out_cap_o        = out_cap_q;

  `BIS_ASSERT(a_count_le_cap, count_q <= cap_q, "element count above capacity")
  `BIS_ASSERT(a_cap_le_depth, cap_q <= DEPTH_C, "capacity above depth")
  `BIS_ASSERT_IMP(a_match_onehot, cmd_i.commit, $onehot0(match_q), "value held twice")
  `BIS_ASSERT_NXT(a_add_grows, cmd_i.commit && kind_q == KIND_ADD && add_ok,
                  count_q == CW'($past(count_q) + CW'(1)), "add did not grow count")

endmodule

[rtl/bis_ctrl.sv]
// ----------------------------------------------------------------------------
// Bounded integer set: controller
// Sequences each item through search and apply, holding when the result
// register is still full.
// ----------------------------------------------------------------------------
module bis_ctrl import bis_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (stat_i.slot_free) state_d = in_valid_i ? ST_SEARCH : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // next item may enter on the same edge that commits the current one
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
      end
      ST_APPLY: begin
        in_ready_o   = stat_i.slot_free;
        cmd_o.commit = stat_i.slot_free;
      end
      default: ;
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
  end

endmodule

[rtl/bounded_integer_set.sv]
// ----------------------------------------------------------------------------
// Bounded integer set: top level
// Set of distinct signed 32-bit values kept in insertion order, with a
// variable capacity; add, remove, query and capacity adjust items.
// ----------------------------------------------------------------------------
// After its transfer each item passes the search state, in which every cell
// compares its entry with the value, then the apply state, in which the cells
// append or close the gap and the count, capacity and result register are
// updated. A new item is taken on the edge that finishes the previous one; a
// result left waiting in the output register holds the finishing cycle until
// it is taken. Writing the capacity register empties the set and loads the
// capacity, saturated at DEPTH; the register port is always ready, and the
// user must use it only between items, which the block does not enforce.
// ----------------------------------------------------------------------------
module bounded_integer_set import bis_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bis_cfg_if.sink   cfg_i,
  bis_in_if.sink    in_i,
  bis_out_if.source out_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (in_i.kind),
    .value_i       (in_i.value),
    .delta_i       (in_i.delta),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_cap_i     (cfg_i.initial_capacity),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_status_o  (out_o.status),
    .out_present_o (out_o.present),
    .out_count_o   (out_o.count),
    .out_cap_o     (out_o.capacity)
  );

endmodule

[bench/tb_bounded_integer_set.sv]
// ----------------------------------------------------------------------------
// Bounded integer set: testbench
// Drives add, remove, query and adjust items through the valid/ready
// channels. It starts with a table of directed items and capacity writes,
// then runs phases of random items, each after a fresh capacity write. Every
// result is checked against a typed row's fixed result or a local mirror.
// ----------------------------------------------------------------------------
module tb_bounded_integer_set import bis_pkg::*; ();

  localparam int unsigned SET_DEPTH  = DEPTH_DEFAULT;
  localparam int unsigned POOL_SIZE  = 96;
  localparam int unsigned N_PHASES   = 8;
  localparam int unsigned PHASE_LEN  = 85;
  localparam int unsigned HOLD_LEN   = 80;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DIR_ROWS   = 27;

  typedef struct packed {
    status_e            status;
    logic               present;
    logic [COUNT_W-1:0] count;
    logic [CAP_W-1:0]   capacity;
  } set_result_t;

  // wr_cfg rows write the capacity register; typed rows carry a fixed result
  typedef struct packed {
    logic                      wr_cfg;
    logic [CAP_W-1:0]          cfg_val;
    kind_e                     kind;
    logic [VALUE_W-1:0]        value;
    logic signed [DELTA_W-1:0] delta;
    logic                      typed;
    set_result_t               res;
  } dir_row_t;

  localparam set_result_t NO_RES = '{STATUS_DONE, 1'b0, 7'd0, 7'd0};

  logic clk_i;
  logic rst_ni;

  bis_cfg_if cfg_bus ();
  bis_in_if  in_bus ();
  bis_out_if out_bus ();

  bounded_integer_set u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // mirror of the set contents
  logic [VALUE_W-1:0] mirror_vals [SET_DEPTH];
  int                 mirror_count;
  int                 mirror_cap;

  set_result_t pending_results [$];
  int          mismatches;
  int          burst_left;
  bit          hold_req;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, 7'd0, KIND_QUERY,  32'h0000_0000,  8'sd0,  1'b1, '{STATUS_MISS, 1'b0, 7'd0, 7'd64}},
    '{1'b0, 7'd0, KIND_ADD,    32'h8000_0000,  8'sd0,  1'b1, '{STATUS_DONE, 1'b0, 7'd1, 7'd64}},
    '{1'b0, 7'd0, KIND_ADD,    32'h7fff_ffff,  8'sd0,  1'b1, '{STATUS_DONE, 1'b0, 7'd2, 7'd64}},
    '{1'b0, 7'd0, KIND_ADD,    32'h8000_0000,  8'sd0,  1'b1, '{STATUS_MISS, 1'b1, 7'd2, 7'd64}},
    '{1'b0, 7'd0, KIND_QUERY,  32'h7fff_ffff,  8'sd0,  1'b0, NO_RES},
    '{1'b0, 7'd0, KIND_ADJUST, 32'h0000_0000,  8'sd64, 1'b1, '{STATUS_DONE, 1'b0, 7'd2, 7'd64}},
    '{1'b0, 7'd0, KIND_ADJUST, 32'h0000_0000, -8'sd64, 1'b1, '{STATUS_DONE, 1'b0, 7'd2, 7'd2}},
    '{1'b0, 7'd0, KIND_ADD,    32'hffff_ffff,  8'sd0,  1'b1, '{STATUS_FULL, 1'b0, 7'd2, 7'd2}},
    // value is a member here, yet adjust still reports it absent
    '{1'b0, 7'd0, KIND_ADJUST, 32'h7fff_ffff,  8'sd0,  1'b1, '{STATUS_DONE, 1'b0, 7'd2, 7'd2}},
    '{1'b0, 7'd0, KIND_ADJUST, 32'h0000_0000,  8'sd1,  1'b1, '{STATUS_DONE, 1'b0, 7'd2, 7'd3}},
    '{1'b0, 7'd0, KIND_ADD,    32'hffff_ffff,  8'sd0,  1'b0, NO_RES},
    '{1'b0, 7'd0, KIND_REMOVE, 32'h8000_0000,  8'sd0,  1'b1, '{STATUS_DONE, 1'b1, 7'd2, 7'd2}},
    '{1'b0, 7'd0, KIND_QUERY,  32'h8000_0000,  8'sd0,  1'b1, '{STATUS_MISS, 1'b0, 7'd2, 7'd2}},
    '{1'b0, 7'd0, KIND_REMOVE, 32'h0000_0005,  8'sd0,  1'b1, '{STATUS_MISS, 1'b0, 7'd2, 7'd2}},
    '{1'b0, 7'd0, KIND_QUERY,  32'hffff_ffff,  8'sd0,  1'b0, NO_RES},
    '{1'b0, 7'd0, KIND_REMOVE, 32'h7fff_ffff,  8'sd0,  1'b1, '{STATUS_DONE, 1'b1, 7'd1, 7'd1}},
    '{1'b0, 7'd0, KIND_REMOVE, 32'hffff_ffff,  8'sd0,  1'b1, '{STATUS_DONE, 1'b1, 7'd0, 7'd0}},
    '{1'b0, 7'd0, KIND_REMOVE, 32'hffff_ffff,  8'sd0,  1'b1, '{STATUS_MISS, 1'b0, 7'd0, 7'd0}},
    '{1'b0, 7'd0, KIND_ADD,    32'h0000_0007,  8'sd0,  1'b1, '{STATUS_FULL, 1'b0, 7'd0, 7'd0}},
    '{1'b0, 7'd0, KIND_ADJUST, 32'h0000_0000, -8'sd64, 1'b1, '{STATUS_DONE, 1'b0, 7'd0, 7'd0}},
    '{1'b1, 7'd127, KIND_ADD,  32'h0000_0000,  8'sd0,  1'b0, NO_RES},
    '{1'b0, 7'd0, KIND_ADD,    32'h0000_0001,  8'sd0,  1'b1, '{STATUS_DONE, 1'b0, 7'd1, 7'd64}},
    '{1'b1, 7'd0, KIND_ADD,    32'h0000_0000,  8'sd0,  1'b0, NO_RES},
    '{1'b0, 7'd0, KIND_ADD,    32'h0000_0001,  8'sd0,  1'b1, '{STATUS_FULL, 1'b0, 7'd0, 7'd0}},
    '{1'b0, 7'd0, KIND_ADJUST, 32'h0000_0000,  8'sd64, 1'b1, '{STATUS_DONE, 1'b0, 7'd0, 7'd64}},
    '{1'b1, 7'd64, KIND_ADD,   32'h0000_0000,  8'sd0,  1'b0, NO_RES},
    '{1'b0, 7'd0, KIND_QUERY,  32'h0000_0001,  8'sd0,  1'b1, '{STATUS_MISS, 1'b0, 7'd0, 7'd64}}
  };

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic set_result_t set_apply(kind_e k, logic [VALUE_W-1:0] v,
                                            logic signed [DELTA_W-1:0] d);
    set_result_t r;
    int          pos;
    int          dv;
    int          room;
    pos = -1;
    dv  = int'(d);
    for (int i = 0; i < mirror_count; i++) begin
      if (pos < 0 && mirror_vals[i] == v) pos = i;
    end
    r.status  = STATUS_DONE;
    r.present = (pos >= 0);
    case (k)
      KIND_ADD: begin
        if (pos >= 0) begin
          r.status = STATUS_MISS;
        end else if (mirror_count >= mirror_cap) begin
          r.status = STATUS_FULL;
        end else begin
          mirror_vals[mirror_count] = v;
          mirror_count++;
        end
      end
      KIND_REMOVE: begin
        if (pos >= 0) begin
          for (int i = pos + 1; i < mirror_count; i++) mirror_vals[i-1] = mirror_vals[i];
          mirror_count--;
        end else begin
          r.status = STATUS_MISS;
        end
        mirror_cap = mirror_count;
      end
      KIND_QUERY: begin
        if (pos < 0) r.status = STATUS_MISS;
      end
      default: begin
        r.present = 1'b0;
        if (dv > 0) begin
          mirror_cap = (mirror_cap + dv > SET_DEPTH) ? SET_DEPTH : mirror_cap + dv;
        end else if (dv < 0) begin
          room = mirror_cap - mirror_count;
          mirror_cap -= (-dv < room) ? -dv : room;
        end
      end
    endcase
    r.count    = COUNT_W'(mirror_count);
    r.capacity = CAP_W'(mirror_cap);
    return r;
  endfunction

  // bursts of transfers separated by random gaps
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_item(kind_e k, logic [VALUE_W-1:0] v, logic signed [DELTA_W-1:0] d,
                           logic typed, set_result_t fixed);
    set_result_t pred;
    pace();
    in_bus.valid <= 1'b1;
    in_bus.kind  <= k;
    in_bus.value <= v;
    in_bus.delta <= d;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    pred = set_apply(k, v, d);
    pending_results.push_back(typed ? fixed : pred);
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_bus.valid            <= 1'b1;
    cfg_bus.initial_capacity <= cap;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    mirror_count = 0;
    mirror_cap   = (cap > SET_DEPTH) ? SET_DEPTH : int'(cap);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic check_result();
    set_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("error: result transfer with nothing outstanding");
    end else begin
      want = pending_results.pop_front();
      if (out_bus.status != want.status || out_bus.present != want.present ||
          out_bus.count != want.count || out_bus.capacity != want.capacity) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: exp status=%0d present=%0d count=%0d cap=%0d, got %0d %0d %0d %0d",
                   want.status, want.present, want.count, want.capacity,
                   out_bus.status, out_bus.present, out_bus.count, out_bus.capacity);
      end
    end
  endtask

  // result side: check transfers, stall on a rolling pattern, long hold on request
  initial begin
    logic [15:0] stall_pat;
    int          pat_age;
    int          pat_idx;
    int          hold_left;
    logic        nxt;
    out_bus.ready = 1'b0;
    pat_age   = 0;
    pat_idx   = 0;
    hold_left = 0;
    stall_pat = '1;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_bus.valid && out_bus.ready) check_result();
        if (hold_req) begin
          hold_req  = 1'b0;
          hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
          hold_left--;
          nxt = 1'b0;
        end else begin
          if (pat_age == 0) begin
            case ($urandom_range(0, 3))
              0:       stall_pat = '1;
              1:       stall_pat = 16'($urandom()) | 16'($urandom());
              default: stall_pat = 16'($urandom());
            endcase
            if (stall_pat == '0) stall_pat[0] = 1'b1;
            pat_age = 64;
          end
          nxt = stall_pat[pat_idx[3:0]];
          pat_idx++;
          pat_age--;
        end
        out_bus.ready <= nxt;
      end
    end
  end

  // no transfer on any channel for too long ends the run
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
          idle = 0;
        else
          idle++;
        if (idle >= IDLE_LIMIT) begin
          $display("error: no transfer for %0d cycles", IDLE_LIMIT);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] pool [POOL_SIZE];
    logic [CAP_W-1:0]   cap;
    int                 add_pct;
    int                 rem_pct;
    int                 qry_pct;
    int                 r;
    int                 dv;
    kind_e              k;
    logic [VALUE_W-1:0] v;

    rst_ni                   = 1'b0;
    in_bus.valid             = 1'b0;
    in_bus.kind              = KIND_ADD;
    in_bus.value             = '0;
    in_bus.delta             = '0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.initial_capacity = '0;
    mirror_count = 0;
    mirror_cap   = RESET_CAP;
    mismatches   = 0;
    burst_left   = 0;
    hold_req     = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_cfg) begin
        drain();
        write_capacity(dir_tab[i].cfg_val);
      end else begin
        send_item(dir_tab[i].kind, dir_tab[i].value, dir_tab[i].delta,
                  dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       cap = 7'd64;
        1:       cap = 7'd0;
        2:       cap = 7'd127;
        3:       cap = 7'd1;
        4:       cap = 7'd65;
        6:       cap = 7'd63;
        default: cap = CAP_W'($urandom_range(0, 127));
      endcase
      drain();
      write_capacity(cap);

      // a small pool of values makes duplicates, hits and removals common
      foreach (pool[i]) pool[i] = $urandom();
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
      pool[2] = 32'h0000_0000;
      pool[3] = 32'hffff_ffff;

      // fill phases push the set towards full capacity
      if (ph % 2 == 0) begin
        add_pct = 70; rem_pct = 8;  qry_pct = 10;
      end else begin
        add_pct = 40; rem_pct = 20; qry_pct = 20;
      end
      if (ph == 2) hold_req = 1'b1;

      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < add_pct)                          k = KIND_ADD;
        else if (r < add_pct + rem_pct)           k = KIND_REMOVE;
        else if (r < add_pct + rem_pct + qry_pct) k = KIND_QUERY;
        else                                      k = KIND_ADJUST;
        v = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : $urandom();
        r = $urandom_range(0, 99);
        if (r < 60)      dv = $urandom_range(1, 64);
        else if (r < 85) dv = -int'($urandom_range(1, 64));
        else             dv = 0;
        send_item(k, v, DELTA_W'(dv), 1'b0, NO_RES);
      end
    end

    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
